>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication with reset disable.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication with reset disable.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pt64_pkg.sv
package pt64_pkg;

    localparam int WIDTH = 64;
    localparam int NUM_BASES = 12;
    localparam int BASE_W = 6;
    localparam int BIDX_W = 4;
    localparam int SHIFT_W = 7;

    // Trial remainder works on one byte of the candidate per step.
    localparam int DIGIT_W = 8;
    localparam int TRIAL_STEPS = WIDTH / DIGIT_W;
    localparam int TCNT_W = $clog2(TRIAL_STEPS + 1);
    // Reciprocal width and width of one partial value (remainder and byte).
    localparam int RECIP_W = 20;
    localparam int RDIG_W = BASE_W + DIGIT_W;

    // Destination of a finished modular product.
    localparam logic [BIDX_W-1:0] PROD_X  = 4'd0;
    localparam logic [BIDX_W-1:0] PROD_B  = 4'd1;
    localparam logic [BIDX_W-1:0] PROD_XK = 4'd2;

    // Small primes used for trial division and as bases.
    function automatic logic [BASE_W-1:0] small_prime(input logic [BIDX_W-1:0] idx);
        logic [BASE_W-1:0] p;
        case (idx)
            4'd0:    p = 6'd2;
            4'd1:    p = 6'd3;
            4'd2:    p = 6'd5;
            4'd3:    p = 6'd7;
            4'd4:    p = 6'd11;
            4'd5:    p = 6'd13;
            4'd6:    p = 6'd17;
            4'd7:    p = 6'd19;
            4'd8:    p = 6'd23;
            4'd9:    p = 6'd29;
            4'd10:   p = 6'd31;
            4'd11:   p = 6'd37;
            default: p = 6'd2;
        endcase
        return p;
    endfunction

    // Rounded-up reciprocals 2^20 / p of the small primes. They give the exact
    // quotient of any partial value below 2^14 after a shift by 20.
    function automatic logic [RECIP_W-1:0] small_recip(input logic [BIDX_W-1:0] idx);
        logic [RECIP_W-1:0] m;
        case (idx)
            4'd0:    m = 20'd524288;
            4'd1:    m = 20'd349526;
            4'd2:    m = 20'd209716;
            4'd3:    m = 20'd149797;
            4'd4:    m = 20'd95326;
            4'd5:    m = 20'd80660;
            4'd6:    m = 20'd61681;
            4'd7:    m = 20'd55189;
            4'd8:    m = 20'd45591;
            4'd9:    m = 20'd36158;
            4'd10:   m = 20'd33826;
            4'd11:   m = 20'd28340;
            default: m = 20'd524288;
        endcase
        return m;
    endfunction

    // Datapath operations requested by the controller.
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_TRIAL  = 4'd2,
        OP_SPLIT  = 4'd3,
        OP_BASE   = 4'd4,
        OP_MUL_AB = 4'd5,
        OP_MUL_BB = 4'd6,
        OP_MUL_XX = 4'd7,
        OP_SHIFTE = 4'd8,
        OP_SQINIT = 4'd9
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BIDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic lt2;
        logic eq_small;
        logic div_small;
        logic trial_done;
        logic split_done;
        logic mul_done;
        logic e_zero;
        logic e_lsb;
        logic x_one;
        logic x_m1;
        logic sq_left;
    } t_status;

endpackage

>>> rtl/pt64_mulmod.sv
// Shift-and-add modular multiplier: one bit of the multiplier a cycle.
module pt64_mulmod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pt64_pkg::WIDTH-1:0] i_x,
    input  logic [pt64_pkg::WIDTH-1:0] i_y,
    input  logic [pt64_pkg::WIDTH-1:0] i_m,
    output logic                       o_done,
    output logic [pt64_pkg::WIDTH-1:0] o_prod
);
    localparam int W = pt64_pkg::WIDTH;

    logic         r_busy;
    logic [W-1:0] r_x, r_y, r_acc, n_acc, n_x;
    logic [W:0]   sum_a, sum_x;

    // Modular additions of the accumulator and doubling of the multiplicand.
    always_comb begin
        sum_a = {1'b0, r_acc} + {1'b0, r_x};
        n_acc = (sum_a >= {1'b0, i_m}) ? W'(sum_a - {1'b0, i_m}) : sum_a[W-1:0];
        if (!r_y[0]) n_acc = r_acc;
        sum_x = {r_x, 1'b0};
        n_x   = (sum_x >= {1'b0, i_m}) ? W'(sum_x - {1'b0, i_m}) : sum_x[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_y == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_acc <= '0;
        end else if (r_busy && r_y != '0) begin
            r_x   <= n_x;
            r_y   <= r_y >> 1;
            r_acc <= n_acc;
        end
    end

    assign o_done = r_busy && (r_y == '0) && !i_start;
    assign o_prod = r_acc;
endmodule

>>> rtl/pt64_datapath.sv
// Registers of one test: modulus, exponent, base power, result and counters.
module pt64_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pt64_pkg::WIDTH-1:0] i_candidate,
    input  pt64_pkg::t_cmd             i_cmd,
    output pt64_pkg::t_status          o_status
);
    localparam int W  = pt64_pkg::WIDTH;
    localparam int PW = pt64_pkg::RDIG_W + pt64_pkg::RECIP_W;

    logic [W-1:0] r_n, r_d, r_e, r_b, r_x;
    logic [pt64_pkg::SHIFT_W-1:0] r_s, r_k;
    logic [W-1:0] r_rem;
    logic [pt64_pkg::TCNT_W-1:0] r_tcnt;
    logic         r_trial_busy;
    logic         trial_end;
    logic [pt64_pkg::BASE_W-1:0]  r_p;
    logic [pt64_pkg::RECIP_W-1:0] r_m;
    logic [pt64_pkg::RDIG_W-1:0]  rem_v, rem_q, rem_qp;
    logic [PW-1:0]                rem_prod;
    logic [pt64_pkg::BASE_W-1:0]  rem_next;
    logic [pt64_pkg::BASE_W-1:0]  r_r;

    logic         mul_start;
    logic [W-1:0] mul_x, mul_y, prod;
    logic         mul_done;

    assign trial_end = r_tcnt == pt64_pkg::TCNT_W'(pt64_pkg::TRIAL_STEPS);

    // Trial remainder, one byte of the candidate a cycle from the top. The
    // quotient of each partial value comes from a multiply by the reciprocal.
    always_comb begin
        rem_v    = {r_r, r_rem[W-1 -: pt64_pkg::DIGIT_W]};
        rem_prod = PW'(rem_v) * PW'(r_m);
        rem_q    = rem_prod[PW-1 -: pt64_pkg::RDIG_W];
        rem_qp   = rem_q * pt64_pkg::RDIG_W'(r_p);
        rem_next = pt64_pkg::BASE_W'(rem_v - rem_qp);
    end

    // Multiplier operand selection.
    always_comb begin
        mul_start = 1'b0;
        mul_x     = r_x;
        mul_y     = r_x;
        case (i_cmd.op)
            pt64_pkg::OP_MUL_AB: begin mul_start = 1'b1; mul_x = r_x; mul_y = r_b; end
            pt64_pkg::OP_MUL_BB: begin mul_start = 1'b1; mul_x = r_b; mul_y = r_b; end
            pt64_pkg::OP_MUL_XX: begin mul_start = 1'b1; end
            default: ;
        endcase
    end

    pt64_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .i_m     (r_n),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trial_busy <= 1'b0;
        end else if (i_cmd.op == pt64_pkg::OP_TRIAL) begin
            r_trial_busy <= 1'b1;
        end else if (r_trial_busy && trial_end) begin
            r_trial_busy <= 1'b0;
        end
    end

    // Datapath register updates per command, plus trial steps, split shifts and products.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pt64_pkg::OP_LOAD: r_n <= i_candidate;
            pt64_pkg::OP_TRIAL: begin
                r_p    <= pt64_pkg::small_prime(i_cmd.idx);
                r_m    <= pt64_pkg::small_recip(i_cmd.idx);
                r_rem  <= r_n;
                r_r    <= '0;
                r_tcnt <= '0;
            end
            pt64_pkg::OP_SPLIT: begin
                r_d <= r_n - W'(1);
                r_s <= '0;
            end
            pt64_pkg::OP_BASE: begin
                r_b <= W'(pt64_pkg::small_prime(i_cmd.idx));
                r_e <= r_d;
                r_x <= W'(1);
            end
            pt64_pkg::OP_SHIFTE: r_e <= r_e >> 1;
            pt64_pkg::OP_SQINIT: r_k <= pt64_pkg::SHIFT_W'(1);
            default: ;
        endcase
        if (r_trial_busy && !trial_end) begin
            r_r    <= rem_next;
            r_rem  <= r_rem << pt64_pkg::DIGIT_W;
            r_tcnt <= r_tcnt + 1'b1;
        end
        if (i_cmd.op == pt64_pkg::OP_NONE && r_d[0] == 1'b0 && r_d != '0) begin
            r_d <= r_d >> 1;
            r_s <= r_s + 1'b1;
        end
        if (mul_done) begin
            case (i_cmd.idx)
                pt64_pkg::PROD_X: r_x <= prod;
                pt64_pkg::PROD_B: r_b <= prod;
                default: begin r_x <= prod; r_k <= r_k + 1'b1; end
            endcase
        end
    end

    always_comb begin
        o_status.lt2        = r_n < W'(2);
        o_status.eq_small   = r_n == W'(r_p);
        o_status.div_small  = r_r == '0;
        o_status.trial_done = r_trial_busy && trial_end;
        o_status.split_done = r_d[0];
        o_status.mul_done   = mul_done;
        o_status.e_zero     = r_e == '0;
        o_status.e_lsb      = r_e[0];
        o_status.x_one      = r_x == W'(1);
        o_status.x_m1       = r_x == r_n - W'(1);
        o_status.sq_left    = r_k < r_s;
    end
endmodule

>>> rtl/pt64_ctrl.sv
// Sequencer: trial division, split of n-1, then one strong test per base.
module pt64_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_is_prime,
    output pt64_pkg::t_cmd       o_cmd,
    input  pt64_pkg::t_status    i_status
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CHECK  = 11'b00000000010,
        S_TRIAL  = 11'b00000000100,
        S_TWAIT  = 11'b00000001000,
        S_SPLIT  = 11'b00000010000,
        S_BASE   = 11'b00000100000,
        S_POWA   = 11'b00001000000,
        S_POWB   = 11'b00010000000,
        S_SQ     = 11'b00100000000,
        S_DONE   = 11'b01000000000,
        S_WAIT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [pt64_pkg::BIDX_W-1:0] r_idx, n_idx;
    logic r_res, n_res, r_ov, n_ov, r_go, n_go;

    // Next-state logic. r_go marks that a multiply has been launched.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_res   = r_res;
        n_ov    = r_ov;
        n_go    = r_go;
        o_cmd.op  = pt64_pkg::OP_NONE;
        o_cmd.idx = '0;
        if (r_ov && !i_out_stall) n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_in_valid && !r_ov) begin
                o_cmd.op = pt64_pkg::OP_LOAD;
                n_state  = S_CHECK;
            end
            S_CHECK: if (i_status.lt2) begin
                n_res = 1'b0; n_state = S_DONE;
            end else begin
                n_idx = '0; n_state = S_TRIAL;
            end
            S_TRIAL: begin
                o_cmd.op = pt64_pkg::OP_TRIAL; o_cmd.idx = r_idx; n_state = S_TWAIT;
            end
            S_TWAIT: if (i_status.trial_done) begin
                if (i_status.eq_small) begin
                    n_res = 1'b1; n_state = S_DONE;
                end else if (i_status.div_small) begin
                    n_res = 1'b0; n_state = S_DONE;
                end else if (r_idx == pt64_pkg::BIDX_W'(pt64_pkg::NUM_BASES-1)) begin
                    o_cmd.op = pt64_pkg::OP_SPLIT; n_state = S_SPLIT;
                end else begin
                    n_idx = r_idx + 1'b1; n_state = S_TRIAL;
                end
            end
            S_SPLIT: if (i_status.split_done) begin
                n_idx = '0; n_state = S_BASE;
            end
            S_BASE: begin
                o_cmd.op = pt64_pkg::OP_BASE; o_cmd.idx = r_idx;
                n_go = 1'b0; n_state = S_POWA;
            end
            S_POWA: if (!r_go) begin
                if (i_status.e_zero) begin
                    if (i_status.x_one || i_status.x_m1) begin
                        n_state = S_WAIT;
                    end else begin
                        o_cmd.op = pt64_pkg::OP_SQINIT; n_state = S_SQ;
                    end
                end else if (i_status.e_lsb) begin
                    o_cmd.op = pt64_pkg::OP_MUL_AB; o_cmd.idx = pt64_pkg::PROD_X;
                    n_go = 1'b1;
                end else begin
                    n_state = S_POWB;
                end
            end else if (i_status.mul_done) begin
                o_cmd.idx = pt64_pkg::PROD_X; n_go = 1'b0; n_state = S_POWB;
            end
            S_POWB: if (!r_go) begin
                o_cmd.op = pt64_pkg::OP_MUL_BB; o_cmd.idx = pt64_pkg::PROD_B; n_go = 1'b1;
            end else if (i_status.mul_done) begin
                o_cmd.op = pt64_pkg::OP_SHIFTE; o_cmd.idx = pt64_pkg::PROD_B;
                n_go = 1'b0; n_state = S_POWA;
            end
            // After a squaring step settles, check for n-1 before squaring again.
            S_SQ: if (!r_go) begin
                if (i_status.x_m1) begin
                    n_state = S_WAIT;
                end else if (!i_status.sq_left) begin
                    n_res = 1'b0; n_state = S_DONE;
                end else begin
                    o_cmd.op = pt64_pkg::OP_MUL_XX; o_cmd.idx = pt64_pkg::PROD_XK;
                    n_go = 1'b1;
                end
            end else if (i_status.mul_done) begin
                o_cmd.idx = pt64_pkg::PROD_XK; n_go = 1'b0;
            end
            S_WAIT: if (r_idx == pt64_pkg::BIDX_W'(pt64_pkg::NUM_BASES-1)) begin
                n_res = 1'b1; n_state = S_DONE;
            end else begin
                n_idx = r_idx + 1'b1; n_state = S_BASE;
            end
            S_DONE: if (!r_ov || !i_out_stall) begin
                n_ov = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_go    <= n_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (r_state == S_DONE && (!r_ov || !i_out_stall)) o_is_prime <= r_res;
        r_res <= n_res;
    end

    assign o_in_stall  = (r_state != S_IDLE) || r_ov;
    assign o_out_valid = r_ov;
endmodule

>>> rtl/primality_test_64.sv
// Deterministic primality test of one unsigned candidate.
// Input channel: i_in_valid / o_in_stall with i_candidate; a transaction is
// taken when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall with o_is_prime; one result
// transaction per candidate, in order.
// One candidate is worked on at a time. A candidate below 2 skips the
// tests: the check state sends it straight to the done state. Each of the
// twelve trial remainders works through the candidate one byte a cycle. The
// split of n-1 shifts out its trailing zeros one at a time. Each strong test
// runs the shift-and-add modular multiplier, one multiplier bit a cycle,
// once per exponent bit and once more per set exponent bit, plus up to one
// squaring per remaining power of two; the multiplier sets the throughput.
// The finished result sits in an output register; while the receiver
// stalls it holds, and the next candidate is taken the cycle after it is
// delivered.
// Synchronous active-low reset returns the sequencer to idle and drops the
// output valid; no result is pending after reset.
module primality_test_64 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [pt64_pkg::WIDTH-1:0] i_candidate,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_is_prime
);
    pt64_pkg::t_cmd    cmd;
    pt64_pkg::t_status status;

    pt64_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_is_prime  (o_is_prime),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    pt64_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_candidate (i_candidate),
        .i_cmd       (cmd),
        .o_status    (status)
    );
endmodule

>>> rtl/pt64_checker.sv
`include "assert_macros.svh"

// Port-level checks of the primality tester.
module pt64_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_is_prime
);
    // A stalled result holds its value.
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_is_prime) && o_out_valid, "stalled result changed")
    // No input is taken while a result waits.
    `ASSERT_IMPLIES(a_one, i_clk, i_rst_n, o_out_valid, o_in_stall, "input taken with result pending")
    // A result never appears the cycle after a candidate is taken.
    `ASSERT_NEXT(a_lat, i_clk, i_rst_n, i_in_valid && !o_in_stall, !o_out_valid, "result too early")
endmodule

bind primality_test_64 pt64_checker u_chk (.*);

>>> sim/primality_checker.sv
module primality_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [pt64_pkg::WIDTH-1:0] i_candidate,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic                       i_is_prime,
    output int                         o_fail_count,
    output int                         o_verdicts_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_WITNESSES = 12;
    localparam logic [63:0] WITNESSES [NUM_WITNESSES] = '{
        64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
        64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37
    };

    bit verdict_queue [$];

    // Modular product through a full-width intermediate.
    function automatic logic [63:0] mod_product(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] m);
        logic [127:0] wide;
        wide = {64'd0, a} * {64'd0, b};
        return 64'(wide % {64'd0, m});
    endfunction

    function automatic logic [63:0] mod_power(logic [63:0] b, logic [63:0] e,
                                              logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1;
        b = b % m;
        while (e != 64'd0) begin
            if (e[0]) acc = mod_product(acc, b, m);
            b = mod_product(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Trial division by the small primes, then strong-probable-prime rounds.
    function automatic bit prime_verdict(logic [63:0] raw);
        logic [63:0] n, odd_part, x;
        int twos;
        bit survived;
        n = raw & ({64{1'b1}} >> (64 - pt64_pkg::WIDTH));
        if (n < 64'd2) return 1'b0;
        for (int i = 0; i < NUM_WITNESSES; i++) begin
            if (n == WITNESSES[i]) return 1'b1;
            if (n % WITNESSES[i] == 64'd0) return 1'b0;
        end
        odd_part = n - 64'd1;
        twos = 0;
        while (!odd_part[0]) begin
            odd_part = odd_part >> 1;
            twos++;
        end
        for (int i = 0; i < NUM_WITNESSES; i++) begin
            x = mod_power(WITNESSES[i], odd_part, n);
            survived = (x == 64'd1) || (x == n - 64'd1);
            for (int k = 1; k < twos && !survived; k++) begin
                x = mod_product(x, x, n);
                if (x == n - 64'd1) survived = 1'b1;
            end
            if (!survived) return 1'b0;
        end
        return 1'b1;
    endfunction

    initial begin
        o_fail_count = 0;
        o_verdicts_waiting = 0;
    end

    // Predict on every accepted input transaction, compare every result.
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) verdict_queue.push_back(prime_verdict(i_candidate));
            if (i_out_valid && !i_out_stall) begin
                if (verdict_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected result is_prime=%0b", $realtime, i_is_prime);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = verdict_queue.pop_front();
                    if (want !== i_is_prime) begin
                        if (o_fail_count < 10)
                            $display("%0t: is_prime mismatch: expected %0b, got %0b",
                                     $realtime, want, i_is_prime);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_verdicts_waiting <= verdict_queue.size();
        end
    end

endmodule

>>> sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [63:0] i_candidate;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_is_prime;
    int          fail_count, verdicts_waiting;
    bit          sending_done = 1'b0;

    always #1 i_clk = ~i_clk;

    primality_test_64 i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_candidate(i_candidate),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_is_prime(o_is_prime)
    );

    primality_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_candidate(i_candidate),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_is_prime(o_is_prime),
        .o_fail_count(fail_count), .o_verdicts_waiting(verdicts_waiting)
    );

    // Directed candidates: edges, small primes, trial-division composites,
    // Carmichael numbers and strong pseudoprimes, large primes.
    localparam int NUM_DIRECTED = 22;
    localparam logic [63:0] DIRECTED [NUM_DIRECTED] = '{
        64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd37, 64'd31, 64'd41, 64'd1369,
        64'd561, 64'd1681, 64'd2047, 64'd1373653, 64'd25326001, 64'd3215031751,
        64'd3825123056546413051, 64'd2305843009213693951, 64'd18446744073709551557,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'd4294967291,
        64'd18446744030759878681
    };

    function automatic logic [63:0] random_candidate();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 64'($urandom_range(0, 1 << 20));
        if (pick < 85) return {32'd0, 32'($urandom)};
        return {32'($urandom), 32'($urandom)};
    endfunction

    // Input side: reset, then directed and random candidates with random gaps.
    initial begin
        int gap;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_candidate <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < NUM_DIRECTED + 300; n++) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_candidate <= (n < NUM_DIRECTED) ? DIRECTED[n] : random_candidate();
            do @(posedge i_clk); while (o_in_stall);
        end
        i_in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Output side: random stall before each result, one long hold-off early on
    // while a quickly finished result waits and the sender keeps offering.
    initial begin
        int gap;
        int taken;
        taken = 0;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (taken == 2) gap = 500;
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    // Verdict once all candidates are in and all results are out.
    initial begin
        wait (sending_done);
        @(posedge i_clk);
        while (verdicts_waiting != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && verdicts_waiting == 0)
            $display("** primality_test_64: PASSED **");
        else
            $display("** primality_test_64: FAILED **");
        $finish;
    end

    // Watchdog.
    initial begin
        #1_000_000_000;
        $display("** primality_test_64: FAILED **");
        $finish;
    end

endmodule
